@@ rtl/mbsr_pkg.sv @@
// ----------------------------------------------------------------------------
// mbsr_pkg
// Shared types and constants for the masked byte search and replace block.
// ----------------------------------------------------------------------------
package mbsr_pkg;

    // Register file geometry: eight registers of up to 64 bits at 8*i
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;

    // Widest pattern and replacement in bytes
    localparam int RUN_BYTES = 8;

    // Register indexes, taken from paddr[5:3]
    localparam logic [2:0] REG_SEARCH_PATTERN      = 3'd0;
    localparam logic [2:0] REG_SEARCH_MASK         = 3'd1;
    localparam logic [2:0] REG_SEARCH_LENGTH       = 3'd2;
    localparam logic [2:0] REG_REPLACE_PATTERN     = 3'd3;
    localparam logic [2:0] REG_REPLACE_MASK        = 3'd4;
    localparam logic [2:0] REG_REPLACE_LENGTH      = 3'd5;
    localparam logic [2:0] REG_REPLACE_MASK_LENGTH = 3'd6;
    localparam logic [2:0] REG_REPLACE_ENABLE      = 3'd7;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_REPORT  = 2'd1,
        KIND_SUMMARY = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic [63:0] search_pattern;
        logic [63:0] search_mask;
        logic [3:0]  search_length;
        logic [63:0] replace_pattern;
        logic [63:0] replace_mask;
        logic [3:0]  replace_length;
        logic [3:0]  replace_mask_length;
        logic        replace_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        search_pattern:      64'h0,
        search_mask:         64'hFFFF_FFFF_FFFF_FFFF,
        search_length:       4'd1,
        replace_pattern:     64'h0,
        replace_mask:        64'h0,
        replace_length:      4'd0,
        replace_mask_length: 4'd0,
        replace_enable:      1'b0
    };

    // Results caused by one request: bytes first, then report, then summary
    typedef struct packed {
        logic [RUN_BYTES-1:0][7:0] bytes;
        logic [3:0]                nbytes;
        logic                      report;
        logic [31:0]               offset;
        logic [63:0]               matched;
        logic                      summary;
        logic [31:0]               total;
    } run_t;

endpackage

@@ rtl/mbsr_regs.sv @@
// ----------------------------------------------------------------------------
// mbsr_regs
// APB register file holding the search and replace configuration.
// ----------------------------------------------------------------------------
module mbsr_regs
    import mbsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg,
    output logic              len_wr
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;
    assign len_wr = wr_en && (idx == REG_SEARCH_LENGTH);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SEARCH_PATTERN:      cfg_next.search_pattern      = pwdata;
                REG_SEARCH_MASK:         cfg_next.search_mask         = pwdata;
                REG_SEARCH_LENGTH:       cfg_next.search_length       = pwdata[3:0];
                REG_REPLACE_PATTERN:     cfg_next.replace_pattern     = pwdata;
                REG_REPLACE_MASK:        cfg_next.replace_mask        = pwdata;
                REG_REPLACE_LENGTH:      cfg_next.replace_length      = pwdata[3:0];
                REG_REPLACE_MASK_LENGTH: cfg_next.replace_mask_length = pwdata[3:0];
                REG_REPLACE_ENABLE:      cfg_next.replace_enable      = pwdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_SEARCH_PATTERN:      prdata = cfg_reg.search_pattern;
            REG_SEARCH_MASK:         prdata = cfg_reg.search_mask;
            REG_SEARCH_LENGTH:       prdata = APB_DW'(cfg_reg.search_length);
            REG_REPLACE_PATTERN:     prdata = cfg_reg.replace_pattern;
            REG_REPLACE_MASK:        prdata = cfg_reg.replace_mask;
            REG_REPLACE_LENGTH:      prdata = APB_DW'(cfg_reg.replace_length);
            REG_REPLACE_MASK_LENGTH: prdata = APB_DW'(cfg_reg.replace_mask_length);
            REG_REPLACE_ENABLE:      prdata = APB_DW'(cfg_reg.replace_enable);
            default:                 prdata = '0;
        endcase
    end

endmodule

@@ rtl/mbsr_cell.sv @@
// ----------------------------------------------------------------------------
// mbsr_cell
// One window position: holds a pending byte, takes the new byte when it is
// the insert position, compares against its pattern byte and hands its byte
// to the left neighbor when the window slides.
// ----------------------------------------------------------------------------
module mbsr_cell
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       shift,
    input  logic       ins,
    input  logic [7:0] in_byte,
    input  logic [7:0] right_byte,
    input  logic [7:0] pat_byte,
    input  logic [7:0] mask_byte,
    output logic [7:0] view,
    output logic       eq
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        view      = ins ? in_byte : byte_reg;
        eq        = ((view ^ pat_byte) & mask_byte) == 8'h00;
        byte_next = byte_reg;
        if (step)
        begin
            // slide left on a miss, else keep the inserted view
            byte_next = shift ? right_byte : view;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

@@ rtl/mbsr_emit.sv @@
// ----------------------------------------------------------------------------
// mbsr_emit
// Holds one request's results and hands them out through an output
// register, one per cycle unless stalled; bytes shift down as they leave.
// ----------------------------------------------------------------------------
module mbsr_emit
    import mbsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  run_t        run,
    input  logic        result_stall,
    output logic        ready,
    output logic        result_valid,
    output logic [1:0]  item_kind,
    output logic [7:0]  out_byte,
    output logic [31:0] match_offset,
    output logic [63:0] matched_bytes,
    output logic [31:0] match_total,
    output logic        last_of_run
);

    run_t        pend_reg;
    run_t        pend_next;
    logic        pend_any;
    logic        pend_last;
    logic        move;

    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic [31:0] offset_reg;
    logic [31:0] offset_next;
    logic [63:0] matched_reg;
    logic [63:0] matched_next;
    logic [31:0] total_reg;
    logic [31:0] total_next;
    logic        last_reg;
    logic        last_next;

    assign pend_any  = (pend_reg.nbytes != 4'd0) || pend_reg.report || pend_reg.summary;
    assign pend_last = ((pend_reg.nbytes == 4'd1) && !pend_reg.report && !pend_reg.summary)
                    || ((pend_reg.nbytes == 4'd0) && (pend_reg.report ^ pend_reg.summary));
    assign move      = pend_any && (!valid_reg || !result_stall);
    assign ready     = !pend_any || (pend_last && move);

    always_comb
    begin
        pend_next    = pend_reg;
        valid_next   = valid_reg && result_stall;
        kind_next    = kind_reg;
        byte_next    = byte_reg;
        offset_next  = offset_reg;
        matched_next = matched_reg;
        total_next   = total_reg;
        last_next    = last_reg;

        if (move)
        begin
            valid_next   = 1'b1;
            last_next    = pend_last;
            byte_next    = 8'h00;
            offset_next  = '0;
            matched_next = '0;
            total_next   = '0;
            if (pend_reg.nbytes != 4'd0)
            begin
                kind_next        = KIND_BYTE;
                byte_next        = pend_reg.bytes[0];
                pend_next.bytes  = pend_reg.bytes >> 8;
                pend_next.nbytes = pend_reg.nbytes - 4'd1;
            end
            else if (pend_reg.report)
            begin
                kind_next        = KIND_REPORT;
                offset_next      = pend_reg.offset;
                matched_next     = pend_reg.matched;
                pend_next.report = 1'b0;
            end
            else
            begin
                kind_next         = KIND_SUMMARY;
                total_next        = pend_reg.total;
                pend_next.summary = 1'b0;
            end
        end

        if (load)
        begin
            pend_next = run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        byte_reg    <= byte_next;
        offset_reg  <= offset_next;
        matched_reg <= matched_next;
        total_reg   <= total_next;
        last_reg    <= last_next;
    end

    assign result_valid  = valid_reg;
    assign item_kind     = kind_reg;
    assign out_byte      = byte_reg;
    assign match_offset  = offset_reg;
    assign matched_bytes = matched_reg;
    assign match_total   = total_reg;
    assign last_of_run   = last_reg;

endmodule

@@ rtl/masked_byte_search_replace.sv @@
// ----------------------------------------------------------------------------
// masked_byte_search_replace
// Result path: a request is held in the pending register of mbsr_emit, and
// its first result moves into the output register once that is free.
// Throughput: one request per cycle while each gives at most one result and
// result_stall does not hold the output; results leave one per cycle, and
// the next request is taken as the last result of the one before moves out.
// Reset clears the window, offset, match count and the result queue, and
// returns the registers to their reset values.
// ----------------------------------------------------------------------------
module masked_byte_search_replace
    import mbsr_pkg::*;
#(
    parameter int PAT_MAX = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        data_byte,
    input  logic              end_of_stream,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [1:0]        item_kind,
    output logic [7:0]        out_byte,
    output logic [31:0]       match_offset,
    output logic [63:0]       matched_bytes,
    output logic [31:0]       match_total,
    output logic              last_of_run
);

    localparam int CW = $clog2(PAT_MAX + 1);

    cfg_t               cfg;
    logic               len_wr;
    logic               take;
    logic               emit_ready;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [31:0]        offset_reg;
    logic [31:0]        offset_next;
    logic [31:0]        counter_reg;
    logic [31:0]        counter_next;
    logic [31:0]        counter_step;

    logic [CW-1:0]      len_eff;
    logic [3:0]         len4;
    logic [CW-1:0]      pos;
    logic [CW-1:0]      cnt_inc;
    logic               full;
    logic               hit;
    logic               shift;
    logic               rep;

    logic [7:0]         wv [0:RUN_BYTES];
    logic [PAT_MAX-1:0] cell_eq;
    logic [PAT_MAX-1:0] cmp_ok;

    logic [3:0]         rl;
    logic [3:0]         ml;
    logic [7:0]         rp;
    logic [7:0]         rm;
    run_t               run;

    mbsr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .len_wr  (len_wr)
    );

    // Effective pattern length: zero acts as one, clip to the window size
    always_comb
    begin
        if (cfg.search_length == 4'd0)
        begin
            len_eff = CW'(1);
        end
        else if (int'(cfg.search_length) > PAT_MAX)
        begin
            len_eff = CW'(PAT_MAX);
        end
        else
        begin
            len_eff = CW'(cfg.search_length);
        end
    end

    assign len4    = 4'(len_eff);
    assign pos     = (count_reg >= len_eff) ? (len_eff - CW'(1)) : count_reg;
    assign cnt_inc = pos + CW'(1);
    assign full    = (cnt_inc == len_eff);
    assign hit     = full && (&cmp_ok);
    assign shift   = full && !hit;
    assign rep     = cfg.replace_enable;
    assign take    = byte_valid && !byte_stall;

    genvar k;
    generate
        for (k = 0; k < PAT_MAX; k++)
        begin : g_cell
            mbsr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .step       (take),
                .shift      (shift),
                .ins        (pos == CW'(k)),
                .in_byte    (data_byte),
                .right_byte (wv[k+1]),
                .pat_byte   (cfg.search_pattern[8*k +: 8]),
                .mask_byte  (cfg.search_mask[8*k +: 8]),
                .view       (wv[k]),
                .eq         (cell_eq[k])
            );
            assign cmp_ok[k] = cell_eq[k] || (CW'(k) >= len_eff);
        end
        for (k = PAT_MAX; k <= RUN_BYTES; k++)
        begin : g_pad
            assign wv[k] = 8'h00;
        end
    endgenerate

    assign counter_step = (hit && (counter_reg != '1)) ? counter_reg + 32'd1 : counter_reg;

    always_comb
    begin
        count_next   = count_reg;
        offset_next  = offset_reg;
        counter_next = counter_reg;
        if (take)
        begin
            counter_next = counter_step;
            if (hit)
            begin
                count_next  = '0;
                offset_next = offset_reg + 32'(len_eff);
            end
            else if (shift)
            begin
                count_next  = len_eff - CW'(1);
                offset_next = offset_reg + 32'd1;
            end
            else
            begin
                count_next  = cnt_inc;
            end
            if (end_of_stream)
            begin
                count_next   = '0;
                offset_next  = '0;
                counter_next = '0;
            end
        end
        else if (len_wr)
        begin
            // drop pending bytes on a new pattern length
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            offset_reg  <= '0;
            counter_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            offset_reg  <= offset_next;
            counter_reg <= counter_next;
        end
    end

    // Build the result list of this request
    always_comb
    begin
        rl = (cfg.replace_length > 4'(RUN_BYTES)) ? 4'(RUN_BYTES) : cfg.replace_length;
        ml = cfg.replace_mask_length;
        if (ml > rl)
        begin
            ml = rl;
        end
        if (ml > len4)
        begin
            ml = len4;
        end

        run = '0;
        for (int i = 0; i < RUN_BYTES; i++)
        begin
            rp = cfg.replace_pattern[8*i +: 8];
            rm = cfg.replace_mask[8*i +: 8];
            if (hit)
            begin
                run.bytes[i] = (4'(i) < ml) ? ((rp & rm) | (wv[i] & ~rm)) : rp;
            end
            else
            begin
                run.bytes[i] = wv[i];
            end
            run.matched[8*i +: 8] = (4'(i) < len4) ? wv[i] : 8'h00;
        end

        if (!rep)
        begin
            run.nbytes = 4'd0;
        end
        else if (hit)
        begin
            run.nbytes = rl;
        end
        else if (shift)
        begin
            run.nbytes = end_of_stream ? len4 : 4'd1;
        end
        else
        begin
            run.nbytes = end_of_stream ? 4'(cnt_inc) : 4'd0;
        end

        run.report  = hit && !rep;
        run.offset  = offset_reg;
        run.summary = end_of_stream;
        run.total   = counter_step;
    end

    mbsr_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take),
        .run           (run),
        .result_stall  (result_stall),
        .ready         (emit_ready),
        .result_valid  (result_valid),
        .item_kind     (item_kind),
        .out_byte      (out_byte),
        .match_offset  (match_offset),
        .matched_bytes (matched_bytes),
        .match_total   (match_total),
        .last_of_run   (last_of_run)
    );

    assign byte_stall = !emit_ready;

endmodule
